// File: hw/rtl/jmsf_pkg.sv
// Shared types and constants for the JPEG metadata segment filter.
`timescale 1ns / 1ps

package jmsf_pkg;

    // Command queue between the parser and the output serializer
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // JPEG marker codes
    localparam logic [7:0] MK_FF    = 8'hFF;
    localparam logic [7:0] MK_SOI   = 8'hD8;
    localparam logic [7:0] MK_EOI   = 8'hD9;
    localparam logic [7:0] MK_STUFF = 8'h00;
    localparam logic [7:0] MK_RST0  = 8'hD0;
    localparam logic [7:0] MK_RST7  = 8'hD7;
    localparam logic [7:0] MK_APP0  = 8'hE0;
    localparam logic [7:0] MK_SOF0  = 8'hC0;
    localparam logic [7:0] MK_SOFF  = 8'hCF;
    localparam logic [7:0] MK_SOS   = 8'hDA;
    localparam logic [7:0] MK_DQT   = 8'hDB;
    localparam logic [7:0] MK_DRI   = 8'hDD;

    // End status codes
    localparam logic [2:0] ST_EOI       = 3'd0;
    localparam logic [2:0] ST_NOT_JPEG  = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_NO_EOI    = 3'd4;

    // One parsed input byte: up to four output bytes plus end marks
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      nbytes;
        logic            seg;
        logic            fin;
        logic [2:0]      status;
    } t_cmd;

    function automatic logic keep_marker(input logic [7:0] m, input logic [15:0] mask);
        logic r;
        r = 1'b0;
        if (m >= MK_SOF0 && m <= MK_SOFF) r = 1'b1;
        if (m == MK_SOS || m == MK_DQT || m == MK_DRI) r = 1'b1;
        if (m[7:4] == MK_APP0[7:4]) r = mask[m[3:0]];
        return r;
    endfunction

endpackage

// File: hw/rtl/jmsf_front.sv
// Parser: classifies each input byte and emits at most one command per byte.
`timescale 1ns / 1ps

module jmsf_front import jmsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_keep_app_mask,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    typedef enum logic [8:0] {
        PH_SOI0    = 9'b000000001,
        PH_SOI1    = 9'b000000010,
        PH_MFF     = 9'b000000100,
        PH_MCODE   = 9'b000001000,
        PH_LENHI   = 9'b000010000,
        PH_LENLO   = 9'b000100000,
        PH_BODY    = 9'b001000000,
        PH_ENTROPY = 9'b010000000,
        PH_SKIP    = 9'b100000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_marker, n_marker;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_rem, n_rem;
    logic        r_keep, n_keep;
    logic        r_ffp, n_ffp;

    t_cmd        v_cmd;
    logic        v_ended;
    logic        v_accept;
    t_phase      v_after;

    assign o_ready  = !i_q_full;
    assign v_accept = i_valid && o_ready;
    assign v_after  = (r_marker == MK_SOS) ? PH_ENTROPY : PH_MFF;

    always_comb begin
        n_phase  = r_phase;
        n_marker = r_marker;
        n_hi     = r_hi;
        n_rem    = r_rem;
        n_keep   = r_keep;
        n_ffp    = r_ffp;
        v_cmd    = '0;
        v_ended  = 1'b0;

        unique case (r_phase)
            PH_SOI0: begin
                if (i_byte == MK_FF) n_phase = PH_SOI1;
                else begin
                    v_ended = 1'b1;
                    v_cmd.status = ST_NOT_JPEG;
                end
            end
            PH_SOI1: begin
                if (i_byte == MK_SOI) begin
                    v_cmd.data[0] = MK_FF;
                    v_cmd.data[1] = MK_SOI;
                    v_cmd.nbytes  = 3'd2;
                    n_phase = PH_MFF;
                end else begin
                    v_ended = 1'b1;
                    v_cmd.status = ST_NOT_JPEG;
                end
            end
            PH_MFF: begin
                if (i_byte == MK_FF) n_phase = PH_MCODE;
                else begin
                    v_ended = 1'b1;
                    v_cmd.status = ST_MALFORMED;
                end
            end
            PH_MCODE: begin
                if (i_byte == MK_EOI) begin
                    v_cmd.data[0] = MK_FF;
                    v_cmd.data[1] = MK_EOI;
                    v_cmd.nbytes  = 3'd2;
                    v_ended = 1'b1;
                    v_cmd.status = ST_EOI;
                end else if (i_byte == MK_SOI) begin
                    v_ended = 1'b1;
                    v_cmd.status = ST_MALFORMED;
                end else if (i_byte == MK_STUFF ||
                             (i_byte >= MK_RST0 && i_byte <= MK_RST7)) begin
                    v_cmd.data[0] = MK_FF;
                    v_cmd.data[1] = i_byte;
                    v_cmd.nbytes  = 3'd2;
                    n_phase = PH_MFF;
                end else begin
                    n_marker = i_byte;
                    n_phase  = PH_LENHI;
                end
            end
            PH_LENHI: begin
                n_hi    = i_byte;
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                if (r_hi == 8'd0 && i_byte < 8'd2) begin
                    v_ended = 1'b1;
                    v_cmd.status = ST_MALFORMED;
                end else begin
                    n_keep = keep_marker(r_marker, i_keep_app_mask);
                    if (n_keep) begin
                        v_cmd.data[0] = MK_FF;
                        v_cmd.data[1] = r_marker;
                        v_cmd.data[2] = r_hi;
                        v_cmd.data[3] = i_byte;
                        v_cmd.nbytes  = 3'd4;
                        v_cmd.seg     = 1'b1;
                    end
                    n_rem   = {r_hi, i_byte} - 16'd2;
                    n_phase = (n_rem != 16'd0) ? PH_BODY : v_after;
                end
            end
            PH_BODY: begin
                if (r_keep) begin
                    v_cmd.data[0] = i_byte;
                    v_cmd.nbytes  = 3'd1;
                end
                n_rem = r_rem - 16'd1;
                if (n_rem == 16'd0) n_phase = v_after;
            end
            PH_ENTROPY: begin
                if (r_ffp && i_byte == MK_EOI) begin
                    v_cmd.data[0] = MK_FF;
                    v_cmd.data[1] = MK_EOI;
                    v_cmd.nbytes  = 3'd2;
                    v_ended = 1'b1;
                    v_cmd.status = ST_EOI;
                end else begin
                    // a held FF that was not an EOI goes out as data
                    if (r_ffp) begin
                        v_cmd.data[0] = MK_FF;
                        v_cmd.nbytes  = 3'd1;
                    end
                    if (i_byte == MK_FF) n_ffp = 1'b1;
                    else begin
                        v_cmd.data[v_cmd.nbytes[1:0]] = i_byte;
                        v_cmd.nbytes = v_cmd.nbytes + 3'd1;
                        n_ffp = 1'b0;
                    end
                end
            end
            default: begin
                // skip to end of file
            end
        endcase

        if (v_ended) begin
            v_cmd.fin = 1'b1;
            n_ffp     = 1'b0;
            n_phase   = i_last ? PH_SOI0 : PH_SKIP;
        end else if (i_last) begin
            if (n_phase != PH_SKIP) begin
                v_cmd.fin = 1'b1;
                if (n_phase == PH_SOI1) v_cmd.status = ST_NOT_JPEG;
                else if (n_phase == PH_LENHI || n_phase == PH_LENLO || n_phase == PH_BODY)
                    v_cmd.status = ST_TRUNCATED;
                else begin
                    if (n_phase == PH_ENTROPY && n_ffp) begin
                        v_cmd.data[v_cmd.nbytes[1:0]] = MK_FF;
                        v_cmd.nbytes = v_cmd.nbytes + 3'd1;
                    end
                    v_cmd.status = ST_NO_EOI;
                end
            end
            n_ffp   = 1'b0;
            n_phase = PH_SOI0;
        end
    end

    assign o_cmd  = v_cmd;
    assign o_push = v_accept && (v_cmd.nbytes != 3'd0 || v_cmd.fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SOI0;
            r_marker <= '0;
            r_hi     <= '0;
            r_rem    <= '0;
            r_keep   <= 1'b0;
            r_ffp    <= 1'b0;
        end else if (v_accept) begin
            r_phase  <= n_phase;
            r_marker <= n_marker;
            r_hi     <= n_hi;
            r_rem    <= n_rem;
            r_keep   <= n_keep;
            r_ffp    <= n_ffp;
        end
    end

endmodule

// File: hw/rtl/jmsf_queue.sv
// Short command queue between parser and serializer.
`timescale 1ns / 1ps

module jmsf_queue import jmsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_count, n_count;

    assign o_full  = (r_count == QAW'(0) + (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on pop");

endmodule

// File: hw/rtl/jmsf_back.sv
// Serializer: plays each queued command out as one result per cycle while i_tready is high.
`timescale 1ns / 1ps

module jmsf_back import jmsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [15:0] o_tdata,
    output logic [1:0]  o_tuser,
    output logic        o_tlast
);

    logic [1:0] r_idx;
    logic [2:0] v_cnt;
    logic       v_lastitem;
    logic       v_has_data;
    logic       v_take;

    assign v_has_data = (i_cmd.nbytes != 3'd0);
    // status-only command still yields one result
    assign v_cnt      = v_has_data ? i_cmd.nbytes : 3'd1;
    assign v_lastitem = ({1'b0, r_idx} == v_cnt - 3'd1);
    assign v_take     = i_valid && i_tready;

    assign o_tvalid = i_valid;
    assign o_tlast  = i_cmd.fin && v_lastitem;
    assign o_tdata  = {5'd0, (o_tlast ? i_cmd.status : 3'd0),
                       (v_has_data ? i_cmd.data[r_idx] : 8'd0)};
    assign o_tuser  = {i_cmd.seg && (r_idx == 2'd0), v_has_data};
    assign o_pop    = v_take && v_lastitem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (v_take) begin
            r_idx <= v_lastitem ? 2'd0 : r_idx + 2'd1;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ({1'b0, r_idx} < v_cnt))
        else $error("item index past command length");

    a_idx_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("item index not cleared after pop");

endmodule

// File: hw/rtl/jpeg_metadata_segment_filter_unit.sv
// Top level of the JPEG metadata segment filter.
// Path: each input byte's command is registered in the command queue before its results appear on m_axis.
// Throughput: one input byte per cycle while the 4-entry command queue has room;
//   the output side gives one result per cycle while m_axis_tready is high, so a
//   byte's command holds the serializer until all of its results are taken (segment headers give 4, most bytes 0 or 1).
// Reset (i_rst_n low, synchronous): parser back to first SOI byte, queue emptied,
//   keep_app_mask = 0x0001 (keep APP0 only).
`timescale 1ns / 1ps

module jpeg_metadata_segment_filter_unit import jmsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: keep_app_mask
    input  logic        i_cfg_wen,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] end_status, rest zero
    output logic [1:0]  m_axis_tuser,   // [0] out_valid, [1] segment_start
    output logic        m_axis_tlast    // out_end
);

    // APPn keep mask; the user must write it only while the block is idle, which the block does not enforce
    logic [15:0] r_keep_app_mask;

    // Front/back link through the command queue
    logic q_push, q_pop, q_full, q_valid;
    t_cmd push_cmd, head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_app_mask <= 16'h0001;
        end else if (i_cfg_wen) begin
            r_keep_app_mask <= i_cfg_wdata;
        end
    end

    // Front: marker parser, one request per cycle while the queue has room, at most one command per request
    jmsf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_byte          (s_axis_tdata),
        .i_last          (s_axis_tlast),
        .i_keep_app_mask (r_keep_app_mask),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_cmd           (push_cmd)
    );

    // Queue decouples parser stalls from downstream backpressure
    jmsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Back: expands a command into 1..4 result items
    jmsf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (head_cmd),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
